@@ src/kpsd_pkg.sv @@
`default_nettype none
package kpsd_pkg;

   // Register indexes on the configuration port
   localparam logic CSR_LOCKOUT_LENGTH = 1'b0;
   localparam logic CSR_PRESS_LEVEL    = 1'b1;

   localparam int   LOCKOUT_RESET      = 3;
   localparam int   MAX_RESULTS        = 4;
   localparam int   FIFO_DEPTH         = 4;
   localparam int   FIFO_AW            = 2;

   typedef logic [6:0] key_char_type;

   function automatic key_char_type key_char_of(input logic [3:0] key);
      key_char_type ch;
      case (key)
         4'd0:    ch = 7'h31;  // 1
         4'd1:    ch = 7'h32;  // 2
         4'd2:    ch = 7'h33;  // 3
         4'd3:    ch = 7'h41;  // A
         4'd4:    ch = 7'h34;  // 4
         4'd5:    ch = 7'h35;  // 5
         4'd6:    ch = 7'h36;  // 6
         4'd7:    ch = 7'h42;  // B
         4'd8:    ch = 7'h37;  // 7
         4'd9:    ch = 7'h38;  // 8
         4'd10:   ch = 7'h39;  // 9
         4'd11:   ch = 7'h43;  // C
         4'd12:   ch = 7'h2A;  // *
         4'd13:   ch = 7'h30;  // 0
         4'd14:   ch = 7'h23;  // #
         default: ch = 7'h44;  // D
      endcase
      return ch;
   endfunction

endpackage
`default_nettype wire

@@ src/kpsd_lane.sv @@
`default_nettype none
module kpsd_lane #(
   parameter int COUNTER_BITS = 4
) (
   input  wire logic signed [COUNTER_BITS-1:0] counter_cur,
   input  wire logic signed [1:0]              step_cur,
   input  wire logic                           pressed_now,
   input  wire logic signed [COUNTER_BITS-1:0] load_mag,
   output logic signed [COUNTER_BITS-1:0]      counter_nxt,
   output logic signed [1:0]                   step_nxt,
   output logic                                press
);

   logic signed [COUNTER_BITS-1:0] step_ext;
   logic signed [COUNTER_BITS-1:0] counter_chk;
   logic                           stable_pressed;

   assign step_ext = COUNTER_BITS'(step_cur);

   always_comb begin
      counter_nxt = counter_cur;
      step_nxt    = step_cur;
      press       = 1'b0;
      counter_chk = counter_cur;
      stable_pressed = 1'b0;
      if (step_cur != 2'sd0 && counter_cur != '0) begin
         // still locked: advance and ignore the sample
         counter_nxt = counter_cur + step_ext;
      end else begin
         if (step_cur != 2'sd0) begin
            counter_chk = -step_ext;
            step_nxt    = 2'sd0;
         end
         counter_nxt    = counter_chk;
         stable_pressed = counter_chk > 0;
         if (pressed_now && !stable_pressed) begin
            counter_nxt = load_mag;
            step_nxt    = -2'sd1;
            press       = 1'b1;
         end else if (!pressed_now && stable_pressed) begin
            counter_nxt = -load_mag;
            step_nxt    = 2'sd1;
         end
      end
   end

endmodule
`default_nettype wire

@@ src/kpsd_merge.sv @@
`default_nettype none
module kpsd_merge #(
   parameter int COLUMNS = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   input  wire logic [1:0]          push_row,
   input  wire logic [COLUMNS-1:0]  push_mask,
   output logic                     push_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output kpsd_pkg::key_char_type   rsp_key_char,
   output logic [3:0]               rsp_key_index,
   output logic                     rsp_last
);
   import kpsd_pkg::*;

   localparam int CIDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

   logic [1:0]         row_mem [FIFO_DEPTH];
   logic [COLUMNS-1:0] mask_mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]   count_ff, count_in;

   logic [1:0]         cur_row_ff, cur_row_in;
   logic [COLUMNS-1:0] cur_mask_ff, cur_mask_in;

   logic [COLUMNS-1:0] first_bit;
   logic [CIDX_W-1:0]  sel;
   logic               push, pop, fifo_nonempty;

   assign fifo_nonempty = count_ff != '0;
   assign push_ready    = count_ff != (FIFO_AW+1)'(FIFO_DEPTH);
   assign push          = push_valid && push_ready;

   assign first_bit = cur_mask_ff & (~cur_mask_ff + 1'b1);
   assign rsp_valid = cur_mask_ff != '0;
   assign rsp_last  = (cur_mask_ff & ~first_bit) == '0;

   always_comb begin
      sel = '0;
      for (int c = COLUMNS - 1; c >= 0; c--) begin
         if (cur_mask_ff[c]) sel = CIDX_W'(c);
      end
   end

   assign rsp_key_index = 4'(int'(cur_row_ff) * COLUMNS + int'(sel));
   assign rsp_key_char  = key_char_of(rsp_key_index);

   assign pop = fifo_nonempty && (!rsp_valid || (rsp_ready && rsp_last));

   always_comb begin
      wr_ptr_in   = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in   = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in    = count_ff + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
      cur_row_in  = cur_row_ff;
      cur_mask_in = cur_mask_ff;
      if (pop) begin
         cur_row_in  = row_mem[rd_ptr_ff];
         cur_mask_in = mask_mem[rd_ptr_ff];
      end else if (rsp_valid && rsp_ready) begin
         // drop the key just delivered
         cur_mask_in = cur_mask_ff & ~first_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         row_mem[wr_ptr_ff]  <= push_row;
         mask_mem[wr_ptr_ff] <= push_mask;
      end
      cur_row_ff <= cur_row_in;
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
         cur_mask_ff <= '0;
      end else begin
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
         cur_mask_ff <= cur_mask_in;
      end
   end

endmodule
`default_nettype wire

@@ src/keypad_scan_debounce_top.sv @@
// Keypad scanner with per-key debounce lockout.
// Request channel (req_valid/req_ready): one sampled row, req_row and
// req_column_bits. All keys of that row are updated side by side in the
// cycle the request is accepted, so a request can be taken every cycle.
// Response channel (rsp_valid/rsp_ready): one response per newly accepted
// press, at most four per request, in column order; rsp_last marks the
// final press of a request. A request with no press gives no response.
// The presses of a request take one entry of a four-entry queue,
// behind the request being delivered, then move to a register from
// which they leave one per cycle; req_ready drops only while that
// queue is full, which sets the rate when many presses arrive and
// the receiver stalls. A stalled response holds its fields.
// Configuration (csr_write_enable/csr_index/csr_write_data): index 0 is
// the lockout length, index 1 the column level that means pressed.
// Reset (synchronous) marks every key released with no lockout, sets
// lockout length 3 and press level 0, and empties the queue.
`default_nettype none
module keypad_scan_debounce_top #(
   parameter int ROWS         = 4,
   parameter int COLUMNS      = 4,
   parameter int COUNTER_BITS = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_row,
   input  wire logic [3:0]        req_column_bits,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output kpsd_pkg::key_char_type rsp_key_char,
   output logic [3:0]             rsp_key_index,
   output logic                   rsp_last,
   input  wire logic              csr_write_enable,
   input  wire logic              csr_index,
   input  wire logic [2:0]        csr_write_data
);
   import kpsd_pkg::*;

   localparam int RIDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CMAX   = (1 << (COUNTER_BITS - 1)) - 1;

   logic [2:0] lockout_length_ff;
   logic       press_level_ff;

   logic signed [COUNTER_BITS-1:0] counter_ff [ROWS][COLUMNS];
   logic signed [1:0]              step_ff [ROWS][COLUMNS];

   logic signed [COUNTER_BITS-1:0] counter_in [COLUMNS];
   logic signed [1:0]              step_in [COLUMNS];
   logic [COLUMNS-1:0]             press;
   logic [COLUMNS-1:0]             press_kept;

   logic [RIDX_W-1:0]              row_idx;
   logic                           row_ok;
   logic                           accept;
   logic [3:0]                     len_plus;
   logic signed [COUNTER_BITS-1:0] load_mag;
   logic                           push_ready;

   assign row_idx  = RIDX_W'(req_row);
   assign row_ok   = int'(req_row) < ROWS;
   assign accept   = req_valid && req_ready;
   assign req_ready = push_ready;

   assign len_plus = {1'b0, lockout_length_ff} + 4'd1;
   assign load_mag = (int'(len_plus) > CMAX) ? COUNTER_BITS'(CMAX)
                                             : COUNTER_BITS'(len_plus);

   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_length_ff <= 3'(LOCKOUT_RESET);
         press_level_ff    <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_LOCKOUT_LENGTH: lockout_length_ff <= csr_write_data;
            CSR_PRESS_LEVEL:    press_level_ff    <= csr_write_data[0];
            default:            ;
         endcase
      end
   end

   for (genvar c = 0; c < COLUMNS; c++) begin : g_lane
      logic level;
      if (c < 4) begin : g_pin
         assign level = req_column_bits[c];
      end else begin : g_none
         assign level = 1'b0;
      end

      kpsd_lane #(
         .COUNTER_BITS(COUNTER_BITS)
      ) u_lane (
         .counter_cur (counter_ff[row_idx][c]),
         .step_cur    (step_ff[row_idx][c]),
         .pressed_now (level == press_level_ff),
         .load_mag    (load_mag),
         .counter_nxt (counter_in[c]),
         .step_nxt    (step_in[c]),
         .press       (press[c])
      );
   end

   // keep only the first presses that fit in one request's responses
   always_comb begin
      logic [3:0] n;
      n = '0;
      press_kept = '0;
      for (int c = 0; c < COLUMNS; c++) begin
         if (press[c] && n < 4'(MAX_RESULTS)) begin
            press_kept[c] = 1'b1;
            n = n + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLUMNS; c++) begin
               counter_ff[r][c] <= '1;
               step_ff[r][c]    <= 2'sd0;
            end
         end
      end else if (accept && row_ok) begin
         for (int c = 0; c < COLUMNS; c++) begin
            counter_ff[row_idx][c] <= counter_in[c];
            step_ff[row_idx][c]    <= step_in[c];
         end
      end
   end

   kpsd_merge #(
      .COLUMNS(COLUMNS)
   ) u_merge (
      .clock         (clock),
      .reset         (reset),
      .push_valid    (req_valid && row_ok && (press_kept != '0)),
      .push_row      (req_row),
      .push_mask     (press_kept),
      .push_ready    (push_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_key_char  (rsp_key_char),
      .rsp_key_index (rsp_key_index),
      .rsp_last      (rsp_last)
   );

endmodule
`default_nettype wire

@@ tb/sv/keypad_press_checker.sv @@
`timescale 1ns / 100ps
module keypad_press_checker (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_ready,
   input  wire logic [1:0]             req_row,
   input  wire logic [3:0]             req_column_bits,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire kpsd_pkg::key_char_type rsp_key_char,
   input  wire logic [3:0]             rsp_key_index,
   input  wire logic                   rsp_last,
   input  wire logic                   csr_write_enable,
   input  wire logic                   csr_index,
   input  wire logic [2:0]             csr_write_data,
   output int                          error_count,
   output int                          pending_count
);
   import kpsd_pkg::*;

   localparam int KEYS        = 16;
   localparam int COLS        = 4;
   localparam int COUNTER_MAX = 7;
   // legends in key order, key 0 in the top byte
   localparam logic [8*16-1:0] KEY_LEGENDS = "123A456B789C*0#D";

   typedef struct packed {
      key_char_type key_char;
      logic [3:0]   key_index;
      logic         last;
   } press_result_type;

   press_result_type  press_queue[$];
   logic signed [3:0] lock_count [KEYS];
   logic signed [1:0] lock_step [KEYS];
   logic [2:0]        lockout_len;
   logic              press_level;

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   function automatic logic signed [3:0] lock_load();
      int mag;
      mag = int'(lockout_len) + 1;
      if (mag > COUNTER_MAX) mag = COUNTER_MAX;
      return 4'(mag);
   endfunction

   task automatic scan_row_update(input logic [1:0] row, input logic [3:0] levels);
      int               key;
      int               presses;
      logic             pressed_now;
      logic             held;
      press_result_type res;
      presses = 0;
      for (int col = 0; col < COLS; col++) begin
         key = int'(row) * COLS + col;
         pressed_now = (levels[col] == press_level);
         if (lock_step[key] != 0 && lock_count[key] != 0) begin
            // locked: advance the count, ignore the sample
            lock_count[key] = lock_count[key] + lock_step[key];
         end else begin
            if (lock_step[key] != 0) begin
               // lockout over: settle and recheck this very sample
               lock_count[key] = -lock_step[key];
               lock_step[key]  = 2'sd0;
            end
            held = (lock_count[key] > 0);
            if (pressed_now && !held) begin
               lock_count[key] = lock_load();
               lock_step[key]  = -2'sd1;
               if (presses < MAX_RESULTS) begin
                  res.key_char  = KEY_LEGENDS[8*(15-key) +: 7];
                  res.key_index = 4'(key);
                  res.last      = 1'b0;
                  press_queue.push_back(res);
                  presses++;
               end
            end else if (!pressed_now && held) begin
               lock_count[key] = -lock_load();
               lock_step[key]  = 2'sd1;
            end
         end
      end
      if (presses > 0) begin
         res = press_queue.pop_back();
         res.last = 1'b1;
         press_queue.push_back(res);
      end
   endtask

   always @(posedge clock) begin
      press_result_type want;
      if (reset) begin
         press_queue.delete();
         for (int k = 0; k < KEYS; k++) begin
            lock_count[k] = -4'sd1;
            lock_step[k]  = 2'sd0;
         end
         lockout_len = 3'(LOCKOUT_RESET);
         press_level = 1'b0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_LOCKOUT_LENGTH) lockout_len = csr_write_data;
            else if (csr_index == CSR_PRESS_LEVEL) press_level = csr_write_data[0];
         end
         if (req_valid && req_ready) scan_row_update(req_row, req_column_bits);
         if (rsp_valid && rsp_ready) begin
            if (press_queue.size() == 0) begin
               $error("key_index %0d returned with no press pending", rsp_key_index);
               error_count++;
            end else begin
               want = press_queue.pop_front();
               if (rsp_key_char !== want.key_char) begin
                  $error("key_char expected %h got %h", want.key_char, rsp_key_char);
                  error_count++;
               end
               if (rsp_key_index !== want.key_index) begin
                  $error("key_index expected %0d got %0d", want.key_index, rsp_key_index);
                  error_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last expected %b got %b", want.last, rsp_last);
                  error_count++;
               end
            end
         end
      end
      pending_count = press_queue.size();
   end

endmodule

@@ tb/sv/keypad_scan_debounce_top_tb.sv @@
`timescale 1ns / 100ps
module keypad_scan_debounce_top_tb;
   import kpsd_pkg::*;

   localparam int GAP_MAX      = 11;
   localparam int SETTLE_WAIT  = 6;
   localparam int DRAIN_CYCLES = 8;
   localparam int DRAIN_LIMIT  = 5000;
   localparam int RUN_LIMIT_NS = 2_000_000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid;
   logic         req_ready;
   logic [1:0]   req_row;
   logic [3:0]   req_column_bits;
   logic         rsp_valid;
   logic         rsp_ready;
   key_char_type rsp_key_char;
   logic [3:0]   rsp_key_index;
   logic         rsp_last;
   logic         csr_write_enable;
   logic         csr_index;
   logic [2:0]   csr_write_data;

   int   mismatches;
   int   pending;
   bit   no_gaps = 1'b0;
   int   rsp_hold_len = 0;
   logic level_now = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   keypad_scan_debounce_top uut (.*);

   keypad_press_checker press_check (
      .*,
      .error_count   (mismatches),
      .pending_count (pending)
   );

   task automatic send_row(input logic [1:0] row, input logic [3:0] levels);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_row         <= row;
      req_column_bits <= levels;
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid and hold until every press has come back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic configure(input logic [2:0] lockout, input logic level);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_LOCKOUT_LENGTH;
      csr_write_data   <= lockout;
      @(posedge clock);
      csr_index        <= CSR_PRESS_LEVEL;
      csr_write_data   <= {2'b00, level};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      level_now = level;
   endtask

   // mostly full scans over a slowly changing set of held keys, some noise
   task automatic scan_phase(input int count, input bit busy);
      logic [3:0] held [4];
      int         sent;
      for (int r = 0; r < 4; r++) held[r] = 4'($urandom);
      sent = 0;
      no_gaps = busy;
      while (sent < count) begin
         if ($urandom_range(0, 4) == 0) begin
            send_row(2'($urandom), 4'($urandom));
            sent++;
         end else begin
            if (!busy) no_gaps = ($urandom_range(0, 5) == 0);
            for (int r = 0; r < 4; r++) begin
               if ($urandom_range(0, 3) == 0) held[r] ^= 4'(1 << $urandom_range(0, 3));
               send_row(2'(r), level_now ? held[r] : ~held[r]);
               sent++;
            end
         end
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      int wait_cycles;
      rsp_ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_len > 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_len) @(posedge clock);
            rsp_hold_len = 0;
         end
         wait_cycles = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
         if (wait_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready) && rsp_hold_len == 0);
      end
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("keypad_scan_debounce_top_tb: errors");
      $finish;
   end

   initial begin
      int guard;
      req_valid        = 1'b0;
      req_row          = 2'd0;
      req_column_bits  = 4'd0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_LOCKOUT_LENGTH;
      csr_write_data   = 3'd0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // every key pressed at once, row by row
      for (int r = 0; r < 4; r++) send_row(2'(r), 4'b0000);
      // release row 0 through its lockout, then recheck and release lockout
      repeat (6) send_row(2'd0, 4'b1111);
      for (int i = 0; i < 4; i++) send_row(2'd0, i[0] ? 4'b0101 : 4'b1010);
      send_row(2'd3, 4'b1111);
      send_row(2'd3, 4'b1111);

      settle();
      configure(3'd0, 1'b1);
      scan_phase(55, 1'b0);

      // lockout beyond the counter range saturates
      settle();
      configure(3'd7, 1'b0);
      scan_phase(50, 1'b0);

      // stall responses while requests keep coming back to back
      settle();
      configure(3'd0, 1'b0);
      rsp_hold_len = 80;
      scan_phase(45, 1'b1);

      settle();
      configure(3'd6, 1'b1);
      scan_phase(55, 1'b0);

      settle();
      configure(3'd2, 1'b0);
      scan_phase(50, 1'b0);

      req_valid <= 1'b0;
      @(posedge clock);
      guard = 0;
      while (pending != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending != 0) $error("%0d presses never returned", pending);
      if (mismatches == 0 && pending == 0) begin
         $display("keypad_scan_debounce_top_tb: clean");
      end else begin
         $display("keypad_scan_debounce_top_tb: errors");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/kpsd_pkg.sv
src/kpsd_lane.sv
src/kpsd_merge.sv
src/keypad_scan_debounce_top.sv
tb/sv/keypad_press_checker.sv
tb/sv/keypad_scan_debounce_top_tb.sv
